// File: hw/rtl/dsrt_pkg.sv
// Shared types and constants for the DNS source rate tagger.
package dsrt_pkg;

    // Item operation codes.
    localparam logic [1:0] OP_PACKET = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_SWEEP  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_EXPIRE_SECONDS    = 2'd0;
    localparam logic [1:0] CFG_COUNT_THRESHOLD   = 2'd1;
    localparam logic [1:0] CFG_PAYLOAD_THRESHOLD = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] EXPIRE_SECONDS_RST    = 16'd10;
    localparam logic [15:0] COUNT_THRESHOLD_RST   = 16'd10;
    localparam logic [15:0] PAYLOAD_THRESHOLD_RST = 16'd100;

    localparam logic [15:0] DNS_PORT      = 16'd53;
    localparam logic [31:0] UDP_HDR_BYTES = 32'd8;

    // One table entry as stored in memory.
    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic [16:0] count;
        logic [31:0] created;
    } dsrt_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic tick;
        logic scan_start;
        logic rd_en;
        logic clr_en;
        logic upd_hit;
        logic upd_expire;
        logic insert;
        logic publish;
    } dsrt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       long_dns;
        logic       issue_done;
        logic       chk_valid;
        logic       hit;
        logic       expired;
    } dsrt_status_t;

endpackage

// File: hw/rtl/dns_source_rate_tagger_top.sv
// Tick, ignored and short or non-DNS items go from acceptance through the decode and finish states.
// A long DNS request or a sweep scans the entry memory one entry per cycle through its
// single read port; a packet scan ends early when its source hits an entry.
// A new request is taken only in the idle state, once the last one is published; a finished
// result may wait in the output register while the next request is taken. After reset a
// clearing pass over every entry holds in_ready low; configuration writes are taken throughout.
module dns_source_rate_tagger_top
    import dsrt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [15:0] dest_port,
    input  logic [31:0] src_addr,
    input  logic [15:0] ip_total_len,
    input  logic [3:0]  ip_header_words,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        tunnel_tag,
    output logic        over_threshold,
    output logic        table_full,
    output logic        table_empty
);

    dsrt_cmd_t    cmd;
    dsrt_status_t st;

    assign cfg_ready = 1'b1;

    dsrt_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    dsrt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .operation       (operation),
        .dest_port       (dest_port),
        .src_addr        (src_addr),
        .ip_total_len    (ip_total_len),
        .ip_header_words (ip_header_words),
        .tunnel_tag      (tunnel_tag),
        .over_threshold  (over_threshold),
        .table_full      (table_full),
        .table_empty     (table_empty)
    );

    // A new result never overwrites one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid || out_ready))
        else $error("result published over a pending result");

    // The entry memory has one write port.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_en, cmd.upd_hit, cmd.upd_expire, cmd.insert}))
        else $error("more than one memory write source active");

    // An alerted source is never tagged, and a full table only occurs on a tagged request.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!(tunnel_tag && over_threshold) && (!table_full || tunnel_tag)))
        else $error("inconsistent result flags");

    // No request is taken while a scan uses the read port or the clearing pass runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_en || cmd.clr_en) |-> !in_ready)
        else $error("request accepted during a scan");

endmodule

// File: hw/rtl/dsrt_datapath.sv
// Datapath of the tagger: configuration, clock, entry memory, scan and result registers.
module dsrt_datapath
    import dsrt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  dsrt_cmd_t    cmd,
    output dsrt_status_t st,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic [1:0]   operation,
    input  logic [15:0]  dest_port,
    input  logic [31:0]  src_addr,
    input  logic [15:0]  ip_total_len,
    input  logic [3:0]   ip_header_words,
    output logic         tunnel_tag,
    output logic         over_threshold,
    output logic         table_full,
    output logic         table_empty
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    logic [15:0] expire_reg;
    logic [15:0] count_thr_reg;
    logic [15:0] payload_thr_reg;
    logic [31:0] now_reg;

    logic [1:0]  op_reg;
    logic [15:0] port_reg;
    logic [31:0] addr_reg;
    logic [15:0] total_reg;
    logic [3:0]  words_reg;
    logic [31:0] limit_reg;

    dsrt_entry_t mem [TABLE_ENTRIES];
    dsrt_entry_t rdata_reg;
    logic [CW-1:0] rd_idx_reg;
    logic [AW-1:0] chk_idx_reg;
    logic          chk_valid_reg;
    logic [AW-1:0] free_idx_reg;
    logic          free_found_reg;
    logic [CW-1:0] vcount_reg;

    logic tag_reg;
    logic over_reg;
    logic full_reg;

    logic          we;
    logic [AW-1:0] waddr;
    dsrt_entry_t   wdata;
    logic [31:0]   payload;
    logic [16:0]   cnt_inc;
    logic          over_now;
    logic          insert_ok;

    assign payload   = {16'd0, total_reg} - {26'd0, words_reg, 2'b00} - UDP_HDR_BYTES;
    assign cnt_inc   = rdata_reg.count + 17'd1;
    assign over_now  = cnt_inc > {1'b0, count_thr_reg};
    assign insert_ok = cmd.insert && free_found_reg;

    assign st.op         = op_reg;
    assign st.long_dns   = (port_reg == DNS_PORT) && (payload > {16'd0, payload_thr_reg});
    assign st.issue_done = (rd_idx_reg == CW'(TABLE_ENTRIES));
    assign st.chk_valid  = chk_valid_reg;
    assign st.hit        = chk_valid_reg && rdata_reg.valid && (rdata_reg.addr == addr_reg);
    assign st.expired    = chk_valid_reg && rdata_reg.valid
                           && ($signed(rdata_reg.created) <= $signed(limit_reg));

    // Single write port: clearing, hit update, expiry and insert never overlap.
    always_comb
    begin
        we    = 1'b0;
        waddr = chk_idx_reg;
        wdata = rdata_reg;
        priority if (cmd.clr_en)
        begin
            we    = 1'b1;
            waddr = rd_idx_reg[AW-1:0];
            wdata = '0;
        end
        else if (cmd.upd_hit)
        begin
            we          = 1'b1;
            wdata.count = cnt_inc;
            wdata.valid = !over_now;
        end
        else if (cmd.upd_expire)
        begin
            we          = 1'b1;
            wdata.valid = 1'b0;
        end
        else if (insert_ok)
        begin
            we            = 1'b1;
            waddr         = free_idx_reg;
            wdata.valid   = 1'b1;
            wdata.addr    = addr_reg;
            wdata.count   = 17'd1;
            wdata.created = now_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_idx_reg[AW-1:0]];
        end
    end

    // Item and scan payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg    <= operation;
            port_reg  <= dest_port;
            addr_reg  <= src_addr;
            total_reg <= ip_total_len;
            words_reg <= ip_header_words;
            limit_reg <= now_reg - {16'd0, expire_reg};
        end
        if (cmd.rd_en)
        begin
            chk_idx_reg <= rd_idx_reg[AW-1:0];
        end
        if (chk_valid_reg && !rdata_reg.valid && !free_found_reg)
        begin
            free_idx_reg <= chk_idx_reg;
        end
        if (cmd.publish)
        begin
            tunnel_tag     <= tag_reg;
            over_threshold <= over_reg;
            table_full     <= full_reg;
            table_empty    <= (vcount_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expire_reg      <= EXPIRE_SECONDS_RST;
            count_thr_reg   <= COUNT_THRESHOLD_RST;
            payload_thr_reg <= PAYLOAD_THRESHOLD_RST;
            now_reg         <= '0;
            rd_idx_reg      <= '0;
            chk_valid_reg   <= 1'b0;
            free_found_reg  <= 1'b0;
            vcount_reg      <= '0;
            tag_reg         <= 1'b0;
            over_reg        <= 1'b0;
            full_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_EXPIRE_SECONDS:    expire_reg      <= cfg_data;
                    CFG_COUNT_THRESHOLD:   count_thr_reg   <= cfg_data;
                    CFG_PAYLOAD_THRESHOLD: payload_thr_reg <= cfg_data;
                    default:               ;
                endcase
            end
            if (cmd.tick)
            begin
                now_reg <= now_reg + 32'd1;
            end

            if (cmd.scan_start)
            begin
                rd_idx_reg     <= '0;
                free_found_reg <= 1'b0;
            end
            else if (cmd.rd_en || cmd.clr_en)
            begin
                rd_idx_reg <= rd_idx_reg + CW'(1);
            end
            if (chk_valid_reg && !rdata_reg.valid)
            begin
                free_found_reg <= 1'b1;
            end
            chk_valid_reg <= cmd.rd_en;

            if ((cmd.upd_hit && over_now) || cmd.upd_expire)
            begin
                vcount_reg <= vcount_reg - CW'(1);
            end
            else if (insert_ok)
            begin
                vcount_reg <= vcount_reg + CW'(1);
            end

            if (cmd.load_item)
            begin
                tag_reg  <= 1'b0;
                over_reg <= 1'b0;
                full_reg <= 1'b0;
            end
            else if (cmd.upd_hit)
            begin
                tag_reg  <= !over_now;
                over_reg <= over_now;
            end
            else if (cmd.insert)
            begin
                tag_reg  <= 1'b1;
                full_reg <= !free_found_reg;
            end
        end
    end

endmodule

// File: hw/rtl/dsrt_controller.sv
// Controller state machine of the tagger: sequences clearing, decode, scans and result hand-off.
module dsrt_controller
    import dsrt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  dsrt_status_t st,
    output dsrt_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_PKT,
        ST_SCAN_SWEEP,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = !st.issue_done;
                if (st.issue_done)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (st.op)
                    OP_PACKET:
                    begin
                        if (st.long_dns)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN_PKT;
                        end
                        else
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                    OP_TICK:
                    begin
                        cmd.tick   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    OP_SWEEP:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN_SWEEP;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_SCAN_PKT:
            begin
                // The first matching entry ends the scan; an exhausted scan inserts.
                priority if (st.hit)
                begin
                    cmd.upd_hit = 1'b1;
                    state_next  = ST_FINISH;
                end
                else if (st.issue_done && !st.chk_valid)
                begin
                    cmd.insert = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.rd_en = !st.issue_done;
                end
            end
            ST_SCAN_SWEEP:
            begin
                cmd.upd_expire = st.expired;
                cmd.rd_en      = !st.issue_done;
                if (st.issue_done && !st.chk_valid)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
